// File: hw/rtl/cbgs_pkg.sv
// cbgs_pkg: request/result types, mode codes and palette decode for the
// character/bitmap graphics sequencer; no dependencies
package cbgs_pkg;

    localparam int PIXELS = 8;
    localparam int MC_FLAG_BIT = 3;
    localparam logic [3:0] BLACK_INDEX = 4'h0;

    typedef logic [3:0] t_color;
    typedef logic [3:0][3:0] t_backs;

    typedef enum logic [2:0] {
        MODE_STD_TEXT   = 3'd0,
        MODE_MC_TEXT    = 3'd1,
        MODE_STD_BMP    = 3'd2,
        MODE_MC_BMP     = 3'd3,
        MODE_ECM_TEXT   = 3'd4,
        MODE_BAD_MC_TXT = 3'd5,
        MODE_BAD_BMP    = 3'd6,
        MODE_BAD_MC_BMP = 3'd7
    } t_mode;

    typedef struct packed {
        logic [7:0] gfx_bits;
        logic [7:0] char_byte;
        logic [3:0] color_nibble;
        logic [2:0] fine_scroll;
        logic [1:0] ecm_bmm_bits;
        logic       mcm_bit;
        logic       vertical_border;
        logic       load_allowed;
        logic [3:0] back_color0;
        logic [3:0] back_color1;
        logic [3:0] back_color2;
        logic [3:0] back_color3;
    } t_in_req;

    typedef struct packed {
        logic [3:0] pixel0;
        logic [3:0] pixel1;
        logic [3:0] pixel2;
        logic [3:0] pixel3;
        logic [3:0] pixel4;
        logic [3:0] pixel5;
        logic [3:0] pixel6;
        logic [3:0] pixel7;
        logic [7:0] foreground_mask;
    } t_out_res;

    typedef struct packed {
        logic   multi;
        t_backs c;
    } t_pal;

    // colors selectable by a pixel in the given mode, and pair vs single bit
    function automatic t_pal mode_palette(input t_mode mode, input t_backs backs,
                                          input logic [7:0] ch, input t_color co);
        t_pal pal;
        pal.multi = 1'b0;
        pal.c = {4{BLACK_INDEX}};
        case (mode)
            MODE_STD_TEXT: begin
                pal.c[0] = backs[0];
                pal.c[1] = co;
            end
            MODE_MC_TEXT: begin
                if (co[MC_FLAG_BIT]) begin
                    pal.c[0] = backs[0];
                    pal.c[1] = backs[1];
                    pal.c[2] = backs[2];
                    pal.c[3] = {1'b0, co[2:0]};
                    pal.multi = 1'b1;
                end else begin
                    pal.c[0] = backs[0];
                    pal.c[1] = co;
                end
            end
            MODE_STD_BMP: begin
                pal.c[0] = ch[3:0];
                pal.c[1] = ch[7:4];
            end
            MODE_MC_BMP: begin
                pal.c[0] = backs[0];
                pal.c[1] = ch[7:4];
                pal.c[2] = ch[3:0];
                pal.c[3] = co;
                pal.multi = 1'b1;
            end
            MODE_ECM_TEXT: begin
                pal.c[0] = backs[ch[7:6]];
                pal.c[1] = co;
            end
            MODE_BAD_MC_TXT: pal.multi = co[MC_FLAG_BIT];
            MODE_BAD_BMP:    pal.multi = 1'b0;
            MODE_BAD_MC_BMP: pal.multi = 1'b1;
            default:         pal.multi = 1'b0;
        endcase
        return pal;
    endfunction

endpackage

// File: hw/rtl/char_bitmap_graphics_sequencer.sv
// char_bitmap_graphics_sequencer: eight pixels per character cycle
// depends on cbgs_pkg
//
//   channel | direction | handshake                  | payload
//   request | in        | i_in_valid / o_in_stall    | i_in_data  (t_in_req)
//   result  | out       | o_out_valid / i_out_stall  | o_out_data (t_out_res)
//
// one request per clock unless output stalls; each request is registered, then its result
// the eight pixels are decoded in one pass between the request and result registers
// reset clears the shift register, latched char/color, toggle, pair, mode and backgrounds
// a stalled result holds; the request register fills once, then the request stalls
module char_bitmap_graphics_sequencer
    import cbgs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_res o_out_data
);

    logic     r_in_vld;
    t_in_req  r_in;
    logic     r_out_vld;
    t_out_res r_out;

    logic [7:0] r_shift, n_shift;
    logic [7:0] r_char, n_char;
    t_color     r_color, n_color;
    logic       r_tog, n_tog;
    logic [1:0] r_pair, n_pair;
    logic [2:0] r_mode, n_mode;
    t_backs     r_backs, n_backs;
    t_out_res   n_res;

    logic out_free;
    logic advance;

    assign out_free   = !r_out_vld || !i_out_stall;
    assign advance    = r_in_vld && out_free;
    assign o_in_stall = r_in_vld && !out_free;

    always_comb begin
        t_backs     nb;
        t_backs     backs;
        t_pal       pal;
        logic [3:0] pix [PIXELS];
        logic [7:0] mask;
        logic       bit_sel;
        nb = {r_in.back_color3, r_in.back_color2, r_in.back_color1, r_in.back_color0};
        backs   = r_backs;
        pal     = '0;
        bit_sel = 1'b0;
        n_shift = r_shift;
        n_char  = r_char;
        n_color = r_color;
        n_tog   = r_tog;
        n_pair  = r_pair;
        n_mode  = r_mode;
        n_backs = r_backs;
        mask    = '0;
        for (int p = 0; p < PIXELS; p++) begin
            pix[p] = r_in.back_color0;
        end
        if (!r_in.vertical_border) begin
            for (int p = 0; p < PIXELS; p++) begin
                backs = (p == 0) ? r_backs : nb;
                if (p == 4) begin
                    n_mode = {n_mode[2:1] | r_in.ecm_bmm_bits, r_in.mcm_bit};
                end else if (p == 6) begin
                    n_mode = {r_in.ecm_bmm_bits, n_mode[0]};
                end
                if (3'(p) == r_in.fine_scroll && r_in.load_allowed) begin
                    n_shift = r_in.gfx_bits;
                    n_char  = r_in.char_byte;
                    n_color = r_in.color_nibble;
                    n_tog   = 1'b1;
                end
                pal = mode_palette(t_mode'(n_mode), backs, n_char, n_color);
                if (pal.multi) begin
                    if (n_tog) begin
                        n_pair = n_shift[7:6];
                    end
                    mask[p] = n_pair[1];
                    pix[p]  = pal.c[n_pair];
                end else begin
                    bit_sel = n_shift[7];
                    mask[p] = bit_sel;
                    pix[p]  = pal.c[{1'b0, bit_sel}];
                end
                n_shift = {n_shift[6:0], 1'b0};
                n_tog   = !n_tog;
            end
            n_backs = nb;
        end
        n_res.pixel0 = pix[0];
        n_res.pixel1 = pix[1];
        n_res.pixel2 = pix[2];
        n_res.pixel3 = pix[3];
        n_res.pixel4 = pix[4];
        n_res.pixel5 = pix[5];
        n_res.pixel6 = pix[6];
        n_res.pixel7 = pix[7];
        n_res.foreground_mask = mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_shift   <= '0;
            r_char    <= '0;
            r_color   <= '0;
            r_tog     <= 1'b0;
            r_pair    <= '0;
            r_mode    <= '0;
            r_backs   <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_vld <= i_in_valid;
            end
            if (out_free) begin
                r_out_vld <= r_in_vld;
            end
            if (advance) begin
                r_shift <= n_shift;
                r_char  <= n_char;
                r_color <= n_color;
                r_tog   <= n_tog;
                r_pair  <= n_pair;
                r_mode  <= n_mode;
                r_backs <= n_backs;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= n_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// File: hw/rtl/cbgs_chk.sv
// cbgs_chk: port-level checks for char_bitmap_graphics_sequencer, bound to it
// depends on cbgs_pkg
module cbgs_chk
    import cbgs_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     o_in_stall,
    input t_in_req  i_in_data,
    input logic     o_out_valid,
    input logic     i_out_stall,
    input t_out_res o_out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    // a stalled request holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_stall) |=> (i_in_valid && $stable(i_in_data)))
        else $error("stalled request changed");

    // no result right after reset
    a_rst_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid after reset");

    // request stall only under result backpressure
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("request stalled without output backpressure");

    // an accepted request reaches the output when the output is free
    a_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) ##1 (!o_out_valid || !i_out_stall) |=> o_out_valid)
        else $error("request lost");

endmodule

bind char_bitmap_graphics_sequencer cbgs_chk u_cbgs_chk (.*);

// File: tb/char_bitmap_graphics_sequencer_tb.sv
// char_bitmap_graphics_sequencer_tb: self-checking bench for the graphics sequencer,
// a cycle-level pixel predictor checks every result under random request gaps and stalls
// depends on cbgs_pkg and char_bitmap_graphics_sequencer
`timescale 1ns / 100ps

module char_bitmap_graphics_sequencer_tb;
    import cbgs_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 8;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_in_valid = 1'b0;
    t_in_req  i_in_data = '0;
    logic     i_out_stall = 1'b0;
    logic     o_in_stall;
    logic     o_out_valid;
    t_out_res o_out_data;

    char_bitmap_graphics_sequencer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // predicted sequencer state
    logic [7:0] seq_shift = '0;
    logic [7:0] seq_char = '0;
    logic [3:0] seq_color = '0;
    logic       seq_toggle = 1'b0;
    logic [1:0] seq_pair = '0;
    logic [2:0] seq_mode = '0;
    logic [3:0] seq_backs [4] = '{4'h0, 4'h0, 4'h0, 4'h0};

    t_out_res pending_pixels [$];
    int       mismatch_count = 0;
    int       cycle_count = 0;
    logic     in_idle = 1'b0;
    logic     out_idle = 1'b0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("char_bitmap_graphics_sequencer_tb: errors");
            $finish;
        end
    end

    function automatic t_out_res render_cycle(input t_in_req rq);
        logic [3:0] nb [4];
        logic [3:0] bk [4];
        logic [3:0] pal [4];
        logic [3:0] px [8];
        logic [7:0] mask;
        logic       multi;
        logic [1:0] sel;
        t_out_res   res;
        int         p;
        int         k;
        nb[0] = rq.back_color0;
        nb[1] = rq.back_color1;
        nb[2] = rq.back_color2;
        nb[3] = rq.back_color3;
        if (rq.vertical_border) begin
            res = {{8{nb[0]}}, 8'h00};
            return res;
        end
        mask = '0;
        for (p = 0; p < PIXELS; p++) begin
            for (k = 0; k < 4; k++) begin
                bk[k] = (p == 0) ? seq_backs[k] : nb[k];
                pal[k] = BLACK_INDEX;
            end
            if (p == 4) begin
                seq_mode = {seq_mode[2:1] | rq.ecm_bmm_bits, rq.mcm_bit};
            end else if (p == 6) begin
                seq_mode = {rq.ecm_bmm_bits, seq_mode[0]};
            end
            if (p == int'(rq.fine_scroll) && rq.load_allowed) begin
                seq_shift = rq.gfx_bits;
                seq_char = rq.char_byte;
                seq_color = rq.color_nibble;
                seq_toggle = 1'b1;
            end
            multi = 1'b0;
            case (t_mode'(seq_mode))
                MODE_STD_TEXT: begin
                    pal[0] = bk[0];
                    pal[1] = seq_color;
                end
                MODE_MC_TEXT: begin
                    pal[0] = bk[0];
                    if (seq_color[MC_FLAG_BIT]) begin
                        pal[1] = bk[1];
                        pal[2] = bk[2];
                        pal[3] = {1'b0, seq_color[2:0]};
                        multi = 1'b1;
                    end else begin
                        pal[1] = seq_color;
                    end
                end
                MODE_STD_BMP: begin
                    pal[0] = seq_char[3:0];
                    pal[1] = seq_char[7:4];
                end
                MODE_MC_BMP: begin
                    pal[0] = bk[0];
                    pal[1] = seq_char[7:4];
                    pal[2] = seq_char[3:0];
                    pal[3] = seq_color;
                    multi = 1'b1;
                end
                MODE_ECM_TEXT: begin
                    pal[0] = bk[seq_char[7:6]];
                    pal[1] = seq_color;
                end
                MODE_BAD_MC_TXT: multi = seq_color[MC_FLAG_BIT];
                MODE_BAD_BMP:    multi = 1'b0;
                default:         multi = 1'b1;
            endcase
            if (multi) begin
                if (seq_toggle) begin
                    seq_pair = seq_shift[7:6];
                end
                sel = seq_pair;
                mask[p] = seq_pair[1];
            end else begin
                sel = {1'b0, seq_shift[7]};
                mask[p] = seq_shift[7];
            end
            px[p] = pal[sel];
            seq_shift = seq_shift << 1;
            seq_toggle = ~seq_toggle;
        end
        for (k = 0; k < 4; k++) begin
            seq_backs[k] = nb[k];
        end
        res = {px[0], px[1], px[2], px[3], px[4], px[5], px[6], px[7], mask};
        return res;
    endfunction

    function automatic t_in_req random_request();
        t_in_req rq;
        rq.gfx_bits = 8'($urandom_range(0, 255));
        rq.char_byte = 8'($urandom_range(0, 255));
        rq.color_nibble = 4'($urandom_range(0, 15));
        rq.fine_scroll = 3'($urandom_range(0, 7));
        rq.ecm_bmm_bits = 2'($urandom_range(0, 3));
        rq.mcm_bit = 1'($urandom_range(0, 1));
        rq.vertical_border = 1'($urandom_range(0, 1));
        rq.load_allowed = 1'($urandom_range(0, 1));
        rq.back_color0 = 4'($urandom_range(0, 15));
        rq.back_color1 = 4'($urandom_range(0, 15));
        rq.back_color2 = 4'($urandom_range(0, 15));
        rq.back_color3 = 4'($urandom_range(0, 15));
        return rq;
    endfunction

    // called right after a rising edge; returns right after the accepting edge
    task automatic send_request(input t_in_req rq);
        int gap;
        gap = in_idle ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= rq;
        do @(posedge i_clk); while (o_in_stall);
        pending_pixels.push_back(render_cycle(rq));
    endtask

    initial begin : result_check
        int       stall_cycles;
        int       i;
        t_out_res want;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) begin
                if (pending_pixels.size() == 0) begin
                    $display("%0t unexpected result expected none actual %h", $time, o_out_data);
                    mismatch_count++;
                end else begin
                    want = pending_pixels.pop_front();
                    for (i = 0; i < PIXELS; i++) begin
                        if (o_out_data[39 - 4 * i -: 4] !== want[39 - 4 * i -: 4]) begin
                            $display("%0t pixel%0d expected %h actual %h", $time, i,
                                     want[39 - 4 * i -: 4], o_out_data[39 - 4 * i -: 4]);
                            mismatch_count++;
                        end
                    end
                    if (o_out_data.foreground_mask !== want.foreground_mask) begin
                        $display("%0t foreground_mask expected %h actual %h", $time,
                                 want.foreground_mask, o_out_data.foreground_mask);
                        mismatch_count++;
                    end
                end
                stall_cycles = out_idle ? $urandom_range(0, 19) : 0;
                if (stall_cycles > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (stall_cycles) @(posedge i_clk);
                    i_out_stall <= 1'b0;
                end
            end
        end
    end

    task automatic test_extremes();
        t_in_req rq;
        in_idle = 1'b0;
        out_idle = 1'b0;
        rq = '0;
        send_request(rq);
        rq = '1;
        send_request(rq);
        rq.vertical_border = 1'b0;
        send_request(rq);
        rq = '0;
        rq.gfx_bits = 8'hff;
        rq.fine_scroll = 3'd7;
        rq.load_allowed = 1'b1;
        send_request(rq);
    endtask

    // each mode code is driven in turn, latched mid-character and decoded in the same pass
    task automatic test_each_mode();
        t_in_req rq;
        int      m;
        in_idle = 1'b1;
        out_idle = 1'b1;
        for (m = 0; m <= 8; m++) begin
            rq = random_request();
            rq.vertical_border = 1'b0;
            rq.load_allowed = 1'b1;
            rq.fine_scroll = 3'(m);
            rq.color_nibble[MC_FLAG_BIT] = m[1];
            rq.ecm_bmm_bits = m[2:1];
            rq.mcm_bit = m[0];
            send_request(rq);
        end
    endtask

    // border, load held off, and bitmap switching to multicolor mid-cycle
    task automatic test_mode_switch_and_border();
        t_in_req rq;
        in_idle = 1'b1;
        out_idle = 1'b0;
        rq = random_request();
        rq.vertical_border = 1'b1;
        send_request(rq);
        rq.vertical_border = 1'b0;
        rq.load_allowed = 1'b0;
        send_request(rq);
        rq = random_request();
        rq.vertical_border = 1'b0;
        rq.load_allowed = 1'b1;
        rq.ecm_bmm_bits = 2'b01;
        rq.mcm_bit = 1'b0;
        send_request(rq);
        rq.gfx_bits = 8'h6c;
        rq.mcm_bit = 1'b1;
        rq.fine_scroll = 3'd0;
        send_request(rq);
        rq.ecm_bmm_bits = 2'b01;
        rq.mcm_bit = 1'b0;
        send_request(rq);
        rq.gfx_bits = 8'hb3;
        rq.mcm_bit = 1'b1;
        rq.fine_scroll = 3'd1;
        send_request(rq);
    endtask

    // runs of steady scroll, mode and backgrounds with fresh fetched data, plus noise
    task automatic test_random_streams(input int request_total);
        t_in_req base;
        t_in_req rq;
        int      run_left;
        int      n;
        n = 0;
        run_left = 0;
        while (n < request_total) begin
            if (run_left == 0) begin
                run_left = $urandom_range(8, 60);
                base = random_request();
                in_idle = ($urandom_range(0, 3) != 0);
                out_idle = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 99) < 12) begin
                rq = random_request();
            end else begin
                if ($urandom_range(0, 99) < 6) begin
                    base.ecm_bmm_bits = 2'($urandom_range(0, 3));
                    base.mcm_bit = 1'($urandom_range(0, 1));
                end
                if ($urandom_range(0, 99) < 5) begin
                    base.fine_scroll = 3'($urandom_range(0, 7));
                end
                if ($urandom_range(0, 99) < 6) begin
                    base.back_color0 = 4'($urandom_range(0, 15));
                    base.back_color1 = 4'($urandom_range(0, 15));
                    base.back_color2 = 4'($urandom_range(0, 15));
                    base.back_color3 = 4'($urandom_range(0, 15));
                end
                rq = base;
                rq.gfx_bits = 8'($urandom_range(0, 255));
                rq.char_byte = 8'($urandom_range(0, 255));
                rq.color_nibble = 4'($urandom_range(0, 15));
                rq.vertical_border = ($urandom_range(0, 99) < 3);
                rq.load_allowed = ($urandom_range(0, 99) < 92);
            end
            send_request(rq);
            n++;
            run_left--;
        end
    endtask

    initial begin : run
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_each_mode();
        test_mode_switch_and_border();
        test_random_streams(1800);
        i_in_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("char_bitmap_graphics_sequencer_tb: clean");
        end else begin
            $display("char_bitmap_graphics_sequencer_tb: errors");
        end
        $finish;
    end

endmodule
